/* rtl/tpdt_pkg.sv */
// Package for the two-partial decaying tone unit.
// Shared constants, register indexes, command codes and control types.
// No dependencies.
package tpdt_pkg;

   localparam int SINE_TABLE_BITS = 10;
   localparam int SAMPLE_BITS     = 16;
   localparam int LENGTH_BITS     = 16;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int STEP_W      = 32;
   localparam int BRIGHT_W    = 16;
   localparam int NOTE_LEN_W  = 16;
   localparam int INV_LEN_W   = 25;
   localparam int SAMPLE_W    = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_FUND_STEP  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HARM_STEP  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BRIGHTNESS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_NOTE_LEN   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_INV_LEN    = 3'd4;

   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_IDLE = 4'd0;
   localparam logic [OP_W-1:0] OP_LOAD = 4'd1;
   localparam logic [OP_W-1:0] OP_ROMF = 4'd2;
   localparam logic [OP_W-1:0] OP_ROMH = 4'd3;
   localparam logic [OP_W-1:0] OP_MULH = 4'd4;
   localparam logic [OP_W-1:0] OP_MULR = 4'd5;
   localparam logic [OP_W-1:0] OP_MULE = 4'd6;
   localparam logic [OP_W-1:0] OP_MULG = 4'd7;
   localparam logic [OP_W-1:0] OP_MULS = 4'd8;
   localparam logic [OP_W-1:0] OP_FIN  = 4'd9;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic go;
      logic out_free;
   } stat_type;

endpackage

/* rtl/tpdt_ctrl.sv */
// Sequencer for the two-partial decaying tone unit.
// Steps one item through ROM reads and five multiplier passes; an idle item skips from the first read to the finish.
// Depends on tpdt_pkg.
module tpdt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tpdt_pkg::stat_type stat,
   output tpdt_pkg::cmd_type  cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ROMF = 4'd1;
   localparam logic [3:0] S_ROMH = 4'd2;
   localparam logic [3:0] S_MULH = 4'd3;
   localparam logic [3:0] S_MULR = 4'd4;
   localparam logic [3:0] S_MULE = 4'd5;
   localparam logic [3:0] S_MULG = 4'd6;
   localparam logic [3:0] S_MULS = 4'd7;
   localparam logic [3:0] S_FIN  = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = tpdt_pkg::OP_IDLE;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = tpdt_pkg::OP_LOAD;
               state_in = S_ROMF;
            end
         end
         S_ROMF: begin
            cmd.op   = tpdt_pkg::OP_ROMF;
            state_in = stat.go ? S_ROMH : S_FIN;
         end
         S_ROMH: begin
            cmd.op   = tpdt_pkg::OP_ROMH;
            state_in = S_MULH;
         end
         S_MULH: begin
            cmd.op   = tpdt_pkg::OP_MULH;
            state_in = S_MULR;
         end
         S_MULR: begin
            cmd.op   = tpdt_pkg::OP_MULR;
            state_in = S_MULE;
         end
         S_MULE: begin
            cmd.op   = tpdt_pkg::OP_MULE;
            state_in = S_MULG;
         end
         S_MULG: begin
            cmd.op   = tpdt_pkg::OP_MULG;
            state_in = S_MULS;
         end
         S_MULS: begin
            cmd.op   = tpdt_pkg::OP_MULS;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (stat.out_free) begin
               cmd.op   = tpdt_pkg::OP_FIN;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* rtl/tpdt_datapath.sv */
// Datapath of the two-partial decaying tone unit: registers, note state,
// quarter-wave sine ROM, one shared multiplier and the result register.
// Depends on tpdt_pkg.
module tpdt_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_restart,
   input  logic                                 csr_valid,
   input  logic [tpdt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tpdt_pkg::CSR_DATA_W-1:0]      csr_data,
   input  tpdt_pkg::cmd_type                    cmd,
   output tpdt_pkg::stat_type                   stat,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic signed [tpdt_pkg::SAMPLE_W-1:0] rsp_sample,
   output logic                                 rsp_active,
   output logic                                 rsp_last
);

   localparam int STB      = tpdt_pkg::SINE_TABLE_BITS;
   localparam int TBL_N    = 1 << STB;
   localparam int ADDR_W   = STB + 1;
   localparam int ROM_W    = 15;
   localparam int LEN_W    = tpdt_pkg::LENGTH_BITS;
   localparam int MUL_A_W  = 32;
   localparam int MUL_B_W  = tpdt_pkg::INV_LEN_W;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int QUANT    = (tpdt_pkg::SAMPLE_BITS < 16) ? 16 - tpdt_pkg::SAMPLE_BITS : 0;
   localparam int QHALF    = (QUANT == 0) ? 0 : (1 << (QUANT - 1));
   localparam logic [MUL_B_W-1:0] GAIN_Q16 = MUL_B_W'(22282);
   localparam logic [PROD_W-1:0]  ONE_Q24  = PROD_W'(1) << 24;

   typedef logic [TBL_N:0][ROM_W-1:0] sine_rom_type;

   // shift-and-subtract quotient for the table terms
   function automatic longint unsigned quotient(longint unsigned num, longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = (rem << 1) | ((num >> b) & 64'd1);
         quo = quo << 1;
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | 64'd1;
         end
      end
      return quo;
   endfunction

   // Quarter-wave table: round(32767 * sin(pi/2 * i / N)) by a Q30 Taylor series.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type       rom;
      longint unsigned    x;
      longint unsigned    x2;
      longint unsigned    term;
      longint unsigned    v;
      longint unsigned    div;
      longint             acc;
      for (int i = 0; i <= TBL_N; i++) begin
         x    = (64'd1686629713 * longint'(i)) >> STB;
         x2   = (x * x) >> 30;
         term = x;
         acc  = longint'(x);
         for (int n = 1; n <= 6; n++) begin
            div  = longint'((2 * n) * (2 * n + 1));
            term = quotient((term * x2) >> 30, div);
            if ((n & 1) == 1) begin
               acc = acc - longint'(term);
            end else begin
               acc = acc + longint'(term);
            end
         end
         if (acc < 0) begin
            acc = 0;
         end
         v = (longint'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
         if (v > 64'd32767) begin
            v = 64'd32767;
         end
         rom[i] = ROM_W'(v);
      end
      return rom;
   endfunction

   localparam sine_rom_type SineRom = build_sine_rom();

   // configuration
   logic [tpdt_pkg::STEP_W-1:0]     fund_step_ff;
   logic [tpdt_pkg::STEP_W-1:0]     harm_step_ff;
   logic [tpdt_pkg::BRIGHT_W-1:0]   brightness_ff;
   logic [tpdt_pkg::NOTE_LEN_W-1:0] note_len_ff;
   logic [tpdt_pkg::INV_LEN_W-1:0]  inv_len_ff;

   // note state
   logic [LEN_W-1:0]            frame_ff;
   logic [tpdt_pkg::STEP_W-1:0] fphase_ff;
   logic [tpdt_pkg::STEP_W-1:0] hphase_ff;
   logic                        playing_ff;

   // working registers
   logic [ROM_W-1:0]    rom_q_ff;
   logic                rom_neg_ff;
   logic signed [15:0]  f_ff;
   logic signed [16:0]  sum_ff;
   logic [MUL_B_W-1:0]  env_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic                go_ff;

   logic                                 rsp_valid_ff;
   logic signed [tpdt_pkg::SAMPLE_W-1:0] rsp_sample_ff;
   logic                                 rsp_active_ff;
   logic                                 rsp_last_ff;

   logic [LEN_W-1:0]            len_raw;
   logic [LEN_W-1:0]            len_eff;
   logic [LEN_W-1:0]            frame_in;
   logic                        playing_in;
   logic [tpdt_pkg::BRIGHT_W-1:0] br_sat;
   logic [tpdt_pkg::STEP_W-1:0] phase_sel;
   logic [STB-1:0]              rom_k;
   logic [ADDR_W-1:0]           rom_addr;
   logic [MUL_A_W-1:0]          mul_a;
   logic [MUL_B_W-1:0]          mul_b;
   logic [PROD_W-1:0]           mul_p;
   logic [PROD_W-1:0]           h_full;
   logic signed [16:0]          h_val;
   logic signed [16:0]          sum_in;
   logic [MUL_B_W-1:0]          r_sat;
   logic [PROD_W-1:0]           env_full;
   logic [16:0]                 sum_abs;
   logic [PROD_W-1:0]           fin_full;
   logic [16:0]                 mag;
   logic [16:0]                 mag_q;
   logic signed [tpdt_pkg::SAMPLE_W-1:0] sample_in;
   logic                        last_in;

   assign len_raw    = LEN_W'(note_len_ff);
   assign len_eff    = (len_raw == '0) ? LEN_W'(1) : len_raw;
   assign frame_in   = frame_ff + LEN_W'(1);
   assign playing_in = !((frame_in >= len_eff) || (frame_in == '0));
   assign last_in    = (frame_ff == (len_eff - LEN_W'(1)));
   assign br_sat     = (brightness_ff > 16'h8000) ? 16'h8000 : brightness_ff;

   assign stat.go       = playing_ff && (frame_ff < len_eff);
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   // quadrant folding of the phase into a table address
   assign phase_sel = (cmd.op == tpdt_pkg::OP_ROMH) ? hphase_ff : fphase_ff;
   assign rom_k     = phase_sel[29 -: STB];
   assign rom_addr  = phase_sel[30] ? (ADDR_W'(TBL_N) - {1'b0, rom_k}) : {1'b0, rom_k};

   assign h_full   = prod_ff + (PROD_W'(1) << 14);
   assign h_val    = rom_neg_ff ? -$signed({1'b0, h_full[30:15]})
                                :  $signed({1'b0, h_full[30:15]});
   assign sum_in   = 17'(f_ff) + h_val;
   assign r_sat    = (prod_ff > ONE_Q24) ? ONE_Q24[MUL_B_W-1:0] : prod_ff[MUL_B_W-1:0];
   assign env_full = prod_ff + (PROD_W'(1) << 23);
   assign sum_abs  = sum_ff[16] ? 17'(-sum_ff) : 17'(sum_ff);
   assign fin_full = prod_ff + (PROD_W'(1) << 39);
   assign mag      = {1'b0, fin_full[55:40]};
   assign mag_q    = ((mag + 17'(QHALF)) >> QUANT) << QUANT;
   assign sample_in = sum_ff[16] ? -$signed(mag_q[tpdt_pkg::SAMPLE_W-1:0])
                                 :  $signed(mag_q[tpdt_pkg::SAMPLE_W-1:0]);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         tpdt_pkg::OP_MULH: begin
            mul_a = MUL_A_W'(rom_q_ff);
            mul_b = MUL_B_W'(br_sat);
         end
         tpdt_pkg::OP_MULR: begin
            mul_a = MUL_A_W'(len_eff - frame_ff);
            mul_b = inv_len_ff;
         end
         tpdt_pkg::OP_MULE: begin
            mul_a = MUL_A_W'(r_sat);
            mul_b = r_sat;
         end
         tpdt_pkg::OP_MULG: begin
            mul_a = MUL_A_W'(sum_abs);
            mul_b = GAIN_Q16;
         end
         tpdt_pkg::OP_MULS: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = env_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         fund_step_ff  <= '0;
         harm_step_ff  <= '0;
         brightness_ff <= '0;
         note_len_ff   <= tpdt_pkg::NOTE_LEN_W'(1);
         inv_len_ff    <= tpdt_pkg::INV_LEN_W'(1) << 24;
      end else if (csr_valid) begin
         unique case (csr_index)
            tpdt_pkg::REG_FUND_STEP:  fund_step_ff  <= csr_data;
            tpdt_pkg::REG_HARM_STEP:  harm_step_ff  <= csr_data;
            tpdt_pkg::REG_BRIGHTNESS: brightness_ff <= csr_data[tpdt_pkg::BRIGHT_W-1:0];
            tpdt_pkg::REG_NOTE_LEN:   note_len_ff   <= csr_data[tpdt_pkg::NOTE_LEN_W-1:0];
            tpdt_pkg::REG_INV_LEN:    inv_len_ff    <= csr_data[tpdt_pkg::INV_LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff   <= '0;
         fphase_ff  <= '0;
         hphase_ff  <= '0;
         playing_ff <= 1'b0;
      end else if (cmd.op == tpdt_pkg::OP_LOAD && req_restart) begin
         frame_ff   <= '0;
         fphase_ff  <= '0;
         hphase_ff  <= '0;
         playing_ff <= 1'b1;
      end else if (cmd.op == tpdt_pkg::OP_FIN) begin
         if (go_ff) begin
            frame_ff   <= frame_in;
            fphase_ff  <= fphase_ff + fund_step_ff;
            hphase_ff  <= hphase_ff + harm_step_ff;
            playing_ff <= playing_in;
         end else begin
            playing_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == tpdt_pkg::OP_ROMF || cmd.op == tpdt_pkg::OP_ROMH) begin
         rom_q_ff   <= SineRom[rom_addr];
         rom_neg_ff <= phase_sel[31];
      end
      if (cmd.op == tpdt_pkg::OP_ROMF) begin
         go_ff <= stat.go;
      end
      if (cmd.op == tpdt_pkg::OP_ROMH) begin
         f_ff <= rom_neg_ff ? -$signed({1'b0, rom_q_ff}) : $signed({1'b0, rom_q_ff});
      end
      if (cmd.op == tpdt_pkg::OP_MULR) begin
         sum_ff <= sum_in;
      end
      if (cmd.op == tpdt_pkg::OP_MULG) begin
         env_ff <= env_full[48:24];
      end
      if (cmd.op == tpdt_pkg::OP_MULH || cmd.op == tpdt_pkg::OP_MULR ||
          cmd.op == tpdt_pkg::OP_MULE || cmd.op == tpdt_pkg::OP_MULG ||
          cmd.op == tpdt_pkg::OP_MULS) begin
         prod_ff <= mul_p;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == tpdt_pkg::OP_FIN) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == tpdt_pkg::OP_FIN) begin
         rsp_sample_ff <= go_ff ? sample_in : '0;
         rsp_active_ff <= go_ff;
         rsp_last_ff   <= go_ff && last_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_active = rsp_active_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

/* rtl/two_partial_decaying_tone_unit.sv */
// Top level of the two-partial decaying tone unit.
// Instantiates tpdt_ctrl and tpdt_datapath; depends on tpdt_pkg.
//
//   channel  ports                          role
//   req      req_valid/ready, req_restart   one sample tick in
//   rsp      rsp_valid/ready, sample/flags  one sample out
//   csr      csr_valid/ready, index/data    register write, always ready
//
// A playing tick steps through the accept cycle, two ROM reads, five passes
// through the one shared multiplier and the result write, which loads the
// result register. An idle tick steps through the accept cycle, the first ROM
// read and the result write. The next item is taken while a result waits;
// only a result register still full at the end of an item stalls the sequence.
// Reset is synchronous and clears the registers, note state and controller.
module two_partial_decaying_tone_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_restart,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [tpdt_pkg::SAMPLE_W-1:0] rsp_sample,
   output logic                                 rsp_active,
   output logic                                 rsp_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tpdt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tpdt_pkg::CSR_DATA_W-1:0]      csr_data
);

   tpdt_pkg::cmd_type  cmd;
   tpdt_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   tpdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tpdt_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_restart (req_restart),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_sample  (rsp_sample),
      .rsp_active  (rsp_active),
      .rsp_last    (rsp_last)
   );

endmodule

/* rtl/tpdt_checker.sv */
// Port-level checks for two_partial_decaying_tone_unit, bound to the top level.
// Depends on tpdt_pkg.
module tpdt_port_checks (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [tpdt_pkg::SAMPLE_W-1:0] rsp_sample,
   input logic                                 rsp_active,
   input logic                                 rsp_last
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while previous item in flight");

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_active) |-> (rsp_sample == '0))
      else $error("nonzero sample on inactive item");

   a_last_active: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> rsp_active)
      else $error("last flag on inactive item");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_sample)
         && $stable(rsp_active) && $stable(rsp_last)))
      else $error("stalled result changed");

endmodule

bind two_partial_decaying_tone_unit tpdt_port_checks u_checker (.*);
